// ===== rtl/core/gpioirq_pkg.sv =====
// ----------------------------------------------------------------------------
// gpioirq_pkg
// shared types, register offsets and offset decoding for the gpio irq core
// ----------------------------------------------------------------------------
`default_nettype none

package gpioirq_pkg;

  localparam int unsigned PinCount   = 32;
  localparam int unsigned OffsetBits = 12;

  localparam logic [OffsetBits-1:0] OffDir  = 12'h000;
  localparam logic [OffsetBits-1:0] OffOut  = 12'h004;
  localparam logic [OffsetBits-1:0] OffIn   = 12'h008;
  localparam logic [OffsetBits-1:0] OffIe   = 12'h00C;
  localparam logic [OffsetBits-1:0] OffIs   = 12'h010;
  localparam logic [OffsetBits-1:0] OffTrig = 12'h014;
  localparam logic [OffsetBits-1:0] OffPol  = 12'h018;

  typedef enum logic [2:0] {
    SelDir,
    SelOut,
    SelIn,
    SelIe,
    SelIs,
    SelTrig,
    SelPol,
    SelNone
  } reg_sel_e;

  typedef enum logic {
    ActRead  = 1'b0,
    ActWrite = 1'b1
  } action_e;

  typedef struct packed {
    logic                  action;
    logic [OffsetBits-1:0] offset;
    logic [PinCount-1:0]   write_data;
  } req_t;

  typedef struct packed {
    logic [PinCount-1:0] read_data;
    logic                irq_line;
    logic                bad_offset;
  } rsp_t;

  function automatic reg_sel_e decode_offset(logic [OffsetBits-1:0] off);
    reg_sel_e sel;
    unique case (off)
      OffDir:  sel = SelDir;
      OffOut:  sel = SelOut;
      OffIn:   sel = SelIn;
      OffIe:   sel = SelIe;
      OffIs:   sel = SelIs;
      OffTrig: sel = SelTrig;
      OffPol:  sel = SelPol;
      default: sel = SelNone;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpioirq_in_reg.sv =====
// ----------------------------------------------------------------------------
// gpioirq_in_reg
// input register holding one bus access until the execute step takes it
// ----------------------------------------------------------------------------
`default_nettype none

module gpioirq_in_reg (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic               in_stall_o,
  input  wire gpioirq_pkg::req_t req_i,
  input  wire                logic advance_i,
  output logic               valid_o,
  output gpioirq_pkg::req_t  req_o
);
  import gpioirq_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// ===== rtl/core/gpioirq_regfile.sv =====
// ----------------------------------------------------------------------------
// gpioirq_regfile
// register state, pin evaluation and read mux for one access per cycle while exec_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module gpioirq_regfile (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic exec_i,
  input  wire gpioirq_pkg::req_t req_i,
  output gpioirq_pkg::rsp_t  rsp_o
);
  import gpioirq_pkg::*;

  logic [PinCount-1:0] dir_q, dir_d;
  logic [PinCount-1:0] out_q, out_d;
  logic [PinCount-1:0] ie_q, ie_d;
  logic [PinCount-1:0] is_q, is_d;
  logic [PinCount-1:0] trig_q, trig_d;
  logic [PinCount-1:0] pol_q, pol_d;
  logic [PinCount-1:0] prev_q, prev_d;

  reg_sel_e            sel;
  logic                is_write;
  logic                do_eval;
  logic [PinCount-1:0] pins;
  logic [PinCount-1:0] match;
  logic [PinCount-1:0] edge_set;
  logic [PinCount-1:0] level_val;
  logic [PinCount-1:0] rd;

  assign sel      = decode_offset(req_i.offset);
  assign is_write = (req_i.action == ActWrite);

  // store the written word first, then evaluate on the new values
  always_comb begin
    dir_d   = dir_q;
    out_d   = out_q;
    ie_d    = ie_q;
    trig_d  = trig_q;
    pol_d   = pol_q;
    do_eval = 1'b0;
    if (is_write) begin
      unique case (sel)
        SelDir:  begin dir_d  = req_i.write_data; do_eval = 1'b1; end
        SelOut:  begin out_d  = req_i.write_data; do_eval = 1'b1; end
        SelIe:   begin ie_d   = req_i.write_data; do_eval = 1'b1; end
        SelTrig: begin trig_d = req_i.write_data; do_eval = 1'b1; end
        SelPol:  begin pol_d  = req_i.write_data; do_eval = 1'b1; end
        default: begin end
      endcase
    end
  end

  assign pins      = dir_d & out_d;
  assign match     = ~(pins ^ pol_d) & ie_d;
  assign edge_set  = match & (pins ^ prev_q) & ~trig_d;
  assign level_val = match & trig_d;

  always_comb begin
    is_d   = is_q;
    prev_d = prev_q;
    if (do_eval) begin
      is_d   = (is_q & ~trig_d) | edge_set | level_val;
      prev_d = pins;
    end else if (is_write && sel == SelIs) begin
      is_d = is_q & ~req_i.write_data;
    end
  end

  always_comb begin
    rd = '0;
    if (!is_write) begin
      unique case (sel)
        SelDir:  rd = dir_q;
        SelOut:  rd = out_q;
        SelIn:   rd = dir_q & out_q;
        SelIe:   rd = ie_q;
        SelIs:   rd = is_q;
        SelTrig: rd = trig_q;
        SelPol:  rd = pol_q;
        default: rd = '0;
      endcase
    end
  end

  assign rsp_o.read_data  = rd;
  assign rsp_o.irq_line   = |(is_d & ie_d);
  assign rsp_o.bad_offset = (sel == SelNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= '0;
      out_q  <= '0;
      ie_q   <= '0;
      is_q   <= '0;
      trig_q <= '0;
      pol_q  <= '0;
      prev_q <= '0;
    end else if (exec_i) begin
      dir_q  <= dir_d;
      out_q  <= out_d;
      ie_q   <= ie_d;
      is_q   <= is_d;
      trig_q <= trig_d;
      pol_q  <= pol_d;
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpioirq_out_reg.sv =====
// ----------------------------------------------------------------------------
// gpioirq_out_reg
// result register, holds a response until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module gpioirq_out_reg (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic load_valid_i,
  input  wire gpioirq_pkg::rsp_t rsp_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  wire                logic out_stall_i,
  output gpioirq_pkg::rsp_t  rsp_o
);
  import gpioirq_pkg::*;

  logic valid_q, valid_d;
  rsp_t rsp_q;

  // free when empty or its result leaves this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_valid_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/gpio_controller_edge_level_irq_core.sv =====
// ----------------------------------------------------------------------------
// gpio_controller_edge_level_irq_core
// 32-pin gpio controller with edge and level interrupts behind word registers
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one bus access per transfer: action_i (0 read,
//   1 write), offset_i (byte offset) and write_data_i
//   output channel returns one response per access: read_data_o,
//   irq_line_o (interrupt level after the access) and bad_offset_o
//   path: each access is held in the input register, then in the result
//   register, from which the result transfer leaves once out_stall_i is low
//   throughput: one access per cycle while the output is not stalled, set by
//   the single execute step between the input register and the result register
//   each access reads and updates the register state in the cycle it moves
//   into the result register, so the next access sees its effect
//   reset clears the gpio and interrupt registers and both pipeline valids
//   a stall on the output holds the result and, once the input register is
//   also full, raises in_stall_o in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_controller_edge_level_irq_core (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_stall_o,
  input  wire  logic        action_i,
  input  wire  logic [11:0] offset_i,
  input  wire  logic [31:0] write_data_i,
  output logic              out_valid_o,
  input  wire  logic        out_stall_i,
  output logic [31:0]       read_data_o,
  output logic              irq_line_o,
  output logic              bad_offset_o
);
  import gpioirq_pkg::*;

  req_t in_req;
  req_t ex_req;
  rsp_t ex_rsp;
  rsp_t out_rsp;
  logic ex_valid;
  logic advance;
  logic exec;

  assign in_req.action     = action_i;
  assign in_req.offset     = offset_i;
  assign in_req.write_data = write_data_i;

  assign exec = ex_valid && advance;

  gpioirq_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_req),
    .advance_i  (advance),
    .valid_o    (ex_valid),
    .req_o      (ex_req)
  );

  gpioirq_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .req_i  (ex_req),
    .rsp_o  (ex_rsp)
  );

  gpioirq_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (ex_valid),
    .rsp_i        (ex_rsp),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rsp_o        (out_rsp)
  );

  assign read_data_o  = out_rsp.read_data;
  assign irq_line_o   = out_rsp.irq_line;
  assign bad_offset_o = out_rsp.bad_offset;

endmodule

`default_nettype wire

// ===== rtl/core/gpioirq_checker.sv =====
// ----------------------------------------------------------------------------
// gpioirq_checker
// port-level checks on the gpio irq core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gpioirq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        action_i,
  input wire logic [11:0] offset_i,
  input wire logic [31:0] write_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] read_data_o,
  input wire logic        irq_line_o,
  input wire logic        bad_offset_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o)
      && $stable(irq_line_o) && $stable(bad_offset_o))
    else $error("output changed under stall");

  // input only backs up behind a stalled full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // an accepted access finds the output valid once it has passed the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted transfer did not reach output");

  // bad offsets never return data
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_offset_o |-> read_data_o == 32'h0)
    else $error("bad offset returned data");

endmodule

bind gpio_controller_edge_level_irq_core gpioirq_checker u_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// bus access checks for the 32-pin gpio controller with edge and level irqs
// a shadow of the register file predicts read data, irq level and offset
// flag for every accepted access; directed accesses cover reset values,
// edges, levels, write-one-to-clear and bad offsets, then random traffic
// with stalls on both channels, one long output hold and one full drain
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gpioirq_pkg::*;

  localparam int unsigned RandItems  = 600;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned QuietLimit = 400;
  localparam logic [OffsetBits-1:0] RegOffsets [7] =
    '{OffDir, OffOut, OffIn, OffIe, OffIs, OffTrig, OffPol};

  class gpio_shadow;
    logic [PinCount-1:0] dir_bits;
    logic [PinCount-1:0] out_bits;
    logic [PinCount-1:0] ie_bits;
    logic [PinCount-1:0] is_bits;
    logic [PinCount-1:0] trig_bits;
    logic [PinCount-1:0] pol_bits;
    logic [PinCount-1:0] last_pins;
    rsp_t                pending_rsp[$];
    int unsigned         mismatches;

    function new();
      dir_bits   = '0;
      out_bits   = '0;
      ie_bits    = '0;
      is_bits    = '0;
      trig_bits  = '0;
      pol_bits   = '0;
      last_pins  = '0;
      mismatches = 0;
    endfunction

    function void log_access(action_e act, logic [OffsetBits-1:0] off,
                             logic [PinCount-1:0] data);
      rsp_t                rsp;
      logic                reeval;
      logic [PinCount-1:0] pins;
      logic [PinCount-1:0] match;
      rsp    = '0;
      reeval = 1'b0;
      if (act == ActRead) begin
        case (off)
          OffDir:  rsp.read_data = dir_bits;
          OffOut:  rsp.read_data = out_bits;
          OffIn:   rsp.read_data = dir_bits & out_bits;
          OffIe:   rsp.read_data = ie_bits;
          OffIs:   rsp.read_data = is_bits;
          OffTrig: rsp.read_data = trig_bits;
          OffPol:  rsp.read_data = pol_bits;
          default: rsp.bad_offset = 1'b1;
        endcase
      end else begin
        case (off)
          OffDir:  begin dir_bits  = data; reeval = 1'b1; end
          OffOut:  begin out_bits  = data; reeval = 1'b1; end
          OffIn:   ;
          OffIe:   begin ie_bits   = data; reeval = 1'b1; end
          OffIs:   is_bits = is_bits & ~data;
          OffTrig: begin trig_bits = data; reeval = 1'b1; end
          OffPol:  begin pol_bits  = data; reeval = 1'b1; end
          default: rsp.bad_offset = 1'b1;
        endcase
        if (reeval) begin
          // edge pins latch on a change to the polarity level, level pins follow
          pins      = dir_bits & out_bits;
          match     = ~(pins ^ pol_bits) & ie_bits;
          is_bits   = (is_bits & ~trig_bits) | (match & (pins ^ last_pins) & ~trig_bits)
                      | (match & trig_bits);
          last_pins = pins;
        end
      end
      rsp.irq_line = |(is_bits & ie_bits);
      pending_rsp.push_back(rsp);
    endfunction

    function void check_rsp(logic [PinCount-1:0] rd, logic irq, logic bad);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $error("result transfer with no access outstanding");
        mismatches++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (rd !== exp_rsp.read_data) begin
        $error("read_data expected %h got %h", exp_rsp.read_data, rd);
        mismatches++;
      end
      if (irq !== exp_rsp.irq_line) begin
        $error("irq_line expected %b got %b", exp_rsp.irq_line, irq);
        mismatches++;
      end
      if (bad !== exp_rsp.bad_offset) begin
        $error("bad_offset expected %b got %b", exp_rsp.bad_offset, bad);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  action     = 1'b0;
  logic [OffsetBits-1:0] offset     = '0;
  logic [PinCount-1:0]   write_data = '0;
  logic                  out_stall  = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [PinCount-1:0]   read_data;
  logic                  irq_line;
  logic                  bad_offset;

  logic                  idle_on  = 1'b0;
  logic                  hold_rsp = 1'b0;
  gpio_shadow            sb;

  gpio_controller_edge_level_irq_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .offset_i    (offset),
    .write_data_i(write_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_data_o (read_data),
    .irq_line_o  (irq_line),
    .bad_offset_o(bad_offset)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_access(input action_e act, input logic [OffsetBits-1:0] off,
                             input logic [PinCount-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    offset     <= off;
    write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.log_access(act, off, data);
  endtask

  task automatic wait_for_responses();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_rsp.size() != 0);
    @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_rsp(read_data, irq_line, bad_offset);
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("gpio_controller_edge_level_irq_core verification failed");
    $finish;
  end

  initial begin : stimulus
    action_e               act;
    logic [OffsetBits-1:0] off;
    logic [PinCount-1:0]   data;
    int unsigned           pick;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values
    for (int k = 0; k < 7; k++) send_access(ActRead, RegOffsets[k], $urandom);
    // rising edge on every pin
    send_access(ActWrite, OffIe,   32'hFFFF_FFFF);
    send_access(ActWrite, OffDir,  32'hFFFF_FFFF);
    send_access(ActWrite, OffOut,  32'hFFFF_FFFF);
    send_access(ActWrite, OffPol,  32'hFFFF_FFFF);
    send_access(ActWrite, OffOut,  32'h0000_0000);
    send_access(ActWrite, OffOut,  32'hFFFF_FFFF);
    send_access(ActRead,  OffIs,   32'h0);
    // write one to clear, write to the read-only pin register
    send_access(ActWrite, OffIs,   32'h0000_FFFF);
    send_access(ActWrite, OffIn,   32'hFFFF_FFFF);
    // level pins follow the enable
    send_access(ActWrite, OffTrig, 32'hFFFF_FFFF);
    send_access(ActRead,  OffIs,   32'h0);
    send_access(ActWrite, OffIe,   32'h0000_0000);
    send_access(ActWrite, OffIs,   32'hFFFF_FFFF);
    // unaligned and unmapped offsets
    send_access(ActRead,  12'h001, 32'h0);
    send_access(ActWrite, 12'h01C, 32'hFFFF_FFFF);
    send_access(ActRead,  12'hFFF, 32'h0);
    send_access(ActWrite, 12'h802, 32'hA5A5_5A5A);
    send_access(ActRead,  OffIn,   32'h0);

    for (int n = 0; n < RandItems; n++) begin
      if (n % 40 == 0) idle_on = (n < 450) && ($urandom_range(0, 3) != 0);
      if (n == 150) hold_rsp = 1'b1;
      if (n == 300) wait_for_responses();
      act  = action_e'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 8) off = RegOffsets[$urandom_range(0, 6)];
      else if (pick == 8) off = RegOffsets[$urandom_range(0, 6)] | 12'($urandom_range(1, 3));
      else off = 12'($urandom);
      case ($urandom_range(0, 4))
        0:       data = $urandom;
        1:       data = sb.out_bits ^ (32'h1 << $urandom_range(0, 31));
        2:       data = sb.out_bits ^ ($urandom & $urandom);
        3:       data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: data = $urandom | $urandom;
      endcase
      send_access(act, off, data);
    end
    wait_for_responses();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("gpio_controller_edge_level_irq_core verification clean");
    end else begin
      $display("gpio_controller_edge_level_irq_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
